[design/ddo_pkg.sv]
// ddo_pkg: shared types, constants and helper functions for the wheel odometry block
// used by every module under design/; depends on nothing else
package ddo_pkg;

    // default module parameters
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 16;

    // field widths fixed by the interface
    localparam int ANGLE_W     = 32;
    localparam int WORD_W      = 32;
    localparam int HR_W        = 16;
    localparam int HRB_W       = 20;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 20;

    // trig datapath width, Q2.30 with headroom
    localparam int TRIG_W = 34;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_RADIUS            = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_RADIUS_OVER_BASIS = 8'd1;

    // configuration reset values
    localparam logic [HR_W-1:0]  HALF_RADIUS_RST            = 16'd918;
    localparam logic [HRB_W-1:0] HALF_RADIUS_OVER_BASIS_RST = 20'd14680;

    // angle constants
    localparam longint PI_Q32    = 64'sd13493037705;
    localparam longint PI30      = 64'sd3373259426;
    localparam longint HALF_PI30 = 64'sd1686629713;
    localparam longint INV_GAIN  = 64'sd652032874;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_LIN,
        MUL_ANG,
        MUL_COS,
        MUL_SIN
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LIN,
        ST_MUL_ANG,
        ST_ANG_TAKE,
        ST_WRAP_START,
        ST_TRIG_WAIT,
        ST_MUL_SIN,
        ST_SIN_TAKE,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic     prime;
        logic     load;
        mul_sel_t mul_sel;
        logic     wrap_start;
        logic     commit;
    } ddo_cmd_t;

    typedef struct packed {
        logic have_prev;
        logic trig_busy;
        logic wrap_busy;
        logic out_free;
    } ddo_sts_t;

    // pi in Q(frac) rounded up from the Q32 value
    function automatic longint pi_q_of(input int frac);
        return ((PI_Q32 - 64'sd1) >>> (32 - frac)) + 64'sd1;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sd2147483647)
        begin
            res = 32'sh7FFFFFFF;
        end
        else if (v < -66'sd2147483648)
        begin
            res = 32'sh80000000;
        end
        else
        begin
            res = v[31:0];
        end
        return res;
    endfunction

    // arctangent of 2^-i in Q2.30
    function automatic logic [31:0] atan_at(input logic [4:0] idx);
        logic [31:0] res;
        unique case (idx)
            5'd0:    res = 32'h3243F6A8;
            5'd1:    res = 32'h1DAC6705;
            5'd2:    res = 32'h0FADBAFC;
            5'd3:    res = 32'h07F56EA6;
            5'd4:    res = 32'h03FEAB76;
            5'd5:    res = 32'h01FFD55B;
            5'd6:    res = 32'h00FFFAAA;
            5'd7:    res = 32'h007FFF55;
            5'd8:    res = 32'h003FFFEA;
            5'd9:    res = 32'h001FFFFD;
            5'd10:   res = 32'h000FFFFF;
            5'd11:   res = 32'h0007FFFF;
            5'd12:   res = 32'h0003FFFF;
            5'd13:   res = 32'h0001FFFF;
            5'd14:   res = 32'h0000FFFF;
            5'd15:   res = 32'h00007FFF;
            5'd16:   res = 32'h00003FFF;
            5'd17:   res = 32'h00001FFF;
            5'd18:   res = 32'h00000FFF;
            5'd19:   res = 32'h000007FF;
            5'd20:   res = 32'h000003FF;
            5'd21:   res = 32'h000001FF;
            5'd22:   res = 32'h000000FF;
            5'd23:   res = 32'h0000007F;
            default: res = 32'h00000000;
        endcase
        return res;
    endfunction

endpackage

[design/diff_drive_odometry.sv]
// diff_drive_odometry: top level of the differential-drive wheel odometry block
// depends on ddo_pkg, ddo_ctrl, ddo_datapath (ddo_cordic, ddo_wrap)
//
// Each input item carries the absolute left and right wheel angles (signed Q16.16 radians).
// The first item after reset only primes the stored wheel angles and gives no result; every
// later item yields one result: the wheel deltas against the previous pair give the linear step
// (sum of deltas times half_radius) and the angular step (difference times
// half_radius_over_basis), each rounded to nearest and saturated to 32 bits. x and y advance by
// the linear step times cos and sin of the heading from before this item, with saturation, and
// the heading then takes the angular step and wraps into [-pi, pi). Timing: an item is taken
// only while the sequencer is idle; from acceptance it runs the two step multiplies, waits for
// the CORDIC, runs the cos and sin multiplies and commits into the output register (waiting
// longer if the previous result has not been taken), and no new item is taken before that
// commit. The iterative CORDIC, one rotation stage per cycle, starts in the acceptance
// cycle; the heading wrap runs beside it, a reciprocal-multiply remainder that is done
// before the commit. A finished result waits in the output register while the next item is
// accepted and worked on. Configuration writes (index 0 half_radius, index 1
// half_radius_over_basis, other indexes ignored) are always ready and should be made only
// while no item is in flight.

module diff_drive_odometry
    import ddo_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    localparam int HEAD_W       = FRAC_BITS + 3,
    localparam int OUT_BITS     = 5 * WORD_W + HEAD_W + 1,
    localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [2*ANGLE_W-1:0]   s_axis_tdata,   // left_angle, right_angle
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata,   // pos_x, pos_y, heading, linear_step,
                                                   // angular_step, no_turn, sequence_res, zero pad
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ddo_cmd_t cmd;
    ddo_sts_t sts;

    // unpacked result fields
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [HEAD_W-1:0] heading;
    logic signed [WORD_W-1:0] linear_step;
    logic signed [WORD_W-1:0] angular_step;
    logic                     no_turn;
    logic [WORD_W-1:0]        sequence_res;

    // sequencer: decides when to accept, multiply, start the wrap and commit
    ddo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic, pose state, config registers and output register
    ddo_datapath #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .left_angle   ($signed(s_axis_tdata[ANGLE_W-1:0])),
        .right_angle  ($signed(s_axis_tdata[2*ANGLE_W-1:ANGLE_W])),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .heading      (heading),
        .linear_step  (linear_step),
        .angular_step (angular_step),
        .no_turn      (no_turn),
        .sequence_res (sequence_res)
    );

    // register writes never stall
    assign cfg_ready = 1'b1;

    // pack result fields, first field in the low bits, zero padded to whole bytes
    assign m_axis_tdata = OUT_W'({sequence_res, no_turn, angular_step, linear_step,
                                  heading, pos_y, pos_x});

endmodule

[design/ddo_cordic.sv]
// ddo_cordic: iterative sine/cosine unit, one rotation stage per cycle
// depends on ddo_pkg
module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    localparam int HEAD_W       = FRAC_BITS + 3
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [HEAD_W-1:0] angle,
    output logic                     busy,
    output logic signed [WORD_W-1:0] cos_out,
    output logic signed [WORD_W-1:0] sin_out
);

    localparam int CW = $clog2(CORDIC_STAGES);
    localparam logic [CW-1:0] LAST = CW'(CORDIC_STAGES - 1);
    localparam logic signed [TRIG_W-1:0] PI_T      = TRIG_W'(PI30);
    localparam logic signed [TRIG_W-1:0] HALF_PI_T = TRIG_W'(HALF_PI30);
    localparam logic signed [TRIG_W-1:0] GAIN_T    = TRIG_W'(INV_GAIN);

    logic                     busy_reg;
    logic [CW-1:0]            cnt_reg;
    logic signed [TRIG_W-1:0] x_reg;
    logic signed [TRIG_W-1:0] y_reg;
    logic signed [TRIG_W-1:0] z_reg;
    logic                     neg_reg;

    logic signed [TRIG_W-1:0] z_start;
    logic signed [TRIG_W-1:0] z_fold;
    logic                     neg_fold;
    logic signed [TRIG_W-1:0] xs;
    logic signed [TRIG_W-1:0] ys;
    logic signed [TRIG_W-1:0] atan_step;
    logic signed [TRIG_W-1:0] x_next;
    logic signed [TRIG_W-1:0] y_next;
    logic signed [TRIG_W-1:0] z_next;
    logic signed [TRIG_W-1:0] cos_full;
    logic signed [TRIG_W-1:0] sin_full;

    // heading to Q2.30 and fold into [-pi/2, pi/2]
    always_comb
    begin
        z_start = TRIG_W'(angle) <<< (30 - FRAC_BITS);
        if (z_start > HALF_PI_T)
        begin
            z_fold   = z_start - PI_T;
            neg_fold = 1'b1;
        end
        else if (z_start < -HALF_PI_T)
        begin
            z_fold   = z_start + PI_T;
            neg_fold = 1'b1;
        end
        else
        begin
            z_fold   = z_start;
            neg_fold = 1'b0;
        end
    end

    // one rotation stage
    always_comb
    begin
        xs        = x_reg >>> cnt_reg;
        ys        = y_reg >>> cnt_reg;
        atan_step = $signed({2'b00, atan_at(5'(cnt_reg))});
        if (z_reg >= 0)
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_step;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= GAIN_T;
            y_reg   <= '0;
            z_reg   <= z_fold;
            neg_reg <= neg_fold;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign cos_full = neg_reg ? -x_reg : x_reg;
    assign sin_full = neg_reg ? -y_reg : y_reg;
    assign cos_out  = cos_full[WORD_W-1:0];
    assign sin_out  = sin_full[WORD_W-1:0];
    assign busy     = busy_reg;

endmodule

[design/ddo_wrap.sv]
// ddo_wrap: heading update and wrap to [-pi, pi), remainder by reciprocal multiplication
// three pipelined steps: quotient estimate, remainder, final fold; depends on ddo_pkg
module ddo_wrap
    import ddo_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int HEAD_W   = FRAC_BITS + 3
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [HEAD_W-1:0] heading,
    input  logic signed [WORD_W-1:0] ang,
    output logic                     busy,
    output logic signed [HEAD_W-1:0] result
);

    // offset sum is kept below 2^RW
    localparam int     RW     = 34;
    localparam longint PI_Q   = pi_q_of(FRAC_BITS);
    localparam longint PERIOD = 2 * PI_Q;
    localparam longint OFFSET = PERIOD * ((64'sd2147483648 + PERIOD - 1) / PERIOD);
    // floor(2^RW / period), so the quotient estimate is low by at most one
    localparam longint RECIP  = (64'sd1 <<< RW) / PERIOD;
    localparam int     MW     = $clog2(RECIP + 1);
    localparam int     QW     = RW - $clog2(PERIOD) + 1;
    localparam int     PW     = RW + MW;
    localparam int     NCYC   = 3;
    localparam int     CW     = 2;
    localparam logic signed [RW+1:0] BIAS     = (RW + 2)'(PI_Q + OFFSET);
    localparam logic [MW-1:0]        RECIP_M  = MW'(RECIP);
    localparam logic [RW-1:0]        PERIOD_R = RW'(PERIOD);
    localparam logic signed [RW:0]   PI_EXT   = (RW + 1)'(PI_Q);

    logic                     busy_reg;
    logic [CW-1:0]            cnt_reg;
    logic [RW-1:0]            v_reg;
    logic [QW-1:0]            q_reg;
    logic [RW-1:0]            r_reg;
    logic signed [HEAD_W-1:0] res_reg;

    logic signed [RW+1:0] sum_in;
    logic [PW-1:0]        q_prod;
    logic [RW-1:0]        q_times_p;
    logic [RW-1:0]        r_fold;
    logic signed [RW:0]   centered;

    assign sum_in    = (RW + 2)'(heading) + (RW + 2)'(ang) + BIAS;
    assign q_prod    = PW'(v_reg) * PW'(RECIP_M);
    assign q_times_p = RW'(q_reg) * PERIOD_R;
    // remainder estimate lies in [0, 2 * period), one subtract finishes it
    assign r_fold    = (r_reg >= PERIOD_R) ? (r_reg - PERIOD_R) : r_reg;
    assign centered  = $signed({1'b0, r_fold}) - PI_EXT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NCYC);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= sum_in[RW-1:0];
        end
        q_reg   <= QW'(q_prod >> RW);
        r_reg   <= v_reg - q_times_p;
        res_reg <= centered[HEAD_W-1:0];
    end

    assign result = res_reg;
    assign busy   = busy_reg;

endmodule

[design/ddo_datapath.sv]
// ddo_datapath: config registers, pose state, shared multiplier, trig and wrap units, output register
// depends on ddo_pkg, ddo_cordic, ddo_wrap
module ddo_datapath
    import ddo_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    localparam int HEAD_W       = FRAC_BITS + 3
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ddo_cmd_t                   cmd,
    output ddo_sts_t                   sts,
    input  logic signed [ANGLE_W-1:0]  left_angle,
    input  logic signed [ANGLE_W-1:0]  right_angle,
    input  logic                       cfg_valid,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [WORD_W-1:0]   pos_x,
    output logic signed [WORD_W-1:0]   pos_y,
    output logic signed [HEAD_W-1:0]   heading,
    output logic signed [WORD_W-1:0]   linear_step,
    output logic signed [WORD_W-1:0]   angular_step,
    output logic                       no_turn,
    output logic [WORD_W-1:0]          sequence_res
);

    localparam logic signed [65:0]     ROUND_F    = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0]     ROUND_TRIG = 66'sd1 <<< 29;
    localparam logic signed [HEAD_W-1:0] PI_H     = HEAD_W'(pi_q_of(FRAC_BITS));

    // configuration
    logic [HR_W-1:0]  half_radius_reg;
    logic [HRB_W-1:0] hrb_reg;

    // architectural state
    logic signed [ANGLE_W-1:0] prev_left_reg;
    logic signed [ANGLE_W-1:0] prev_right_reg;
    logic                      have_prev_reg;
    logic signed [WORD_W-1:0]  x_reg;
    logic signed [WORD_W-1:0]  y_reg;
    logic signed [HEAD_W-1:0]  heading_reg;
    logic [WORD_W-1:0]         count_reg;

    // working registers
    logic signed [33:0]       sum_reg;
    logic signed [33:0]       diff_reg;
    logic signed [65:0]       prod_reg;
    mul_sel_t                 tag_reg;
    logic signed [WORD_W-1:0] lin_reg;
    logic signed [WORD_W-1:0] ang_reg;
    logic signed [33:0]       dx_reg;
    logic signed [33:0]       dy_reg;

    // output register
    logic                      out_valid_reg;
    logic signed [WORD_W-1:0]  ox_reg;
    logic signed [WORD_W-1:0]  oy_reg;
    logic signed [HEAD_W-1:0]  oh_reg;
    logic signed [WORD_W-1:0]  olin_reg;
    logic signed [WORD_W-1:0]  oang_reg;
    logic                      onoturn_reg;
    logic [WORD_W-1:0]         oseq_reg;

    logic signed [32:0]       dl_next;
    logic signed [32:0]       dr_next;
    logic signed [33:0]       sum_next;
    logic signed [33:0]       diff_next;
    logic signed [33:0]       mul_a;
    logic signed [31:0]       mul_b;
    logic signed [65:0]       prod_next;
    logic signed [WORD_W-1:0] step_next;
    logic signed [65:0]       trig_wide;
    logic signed [34:0]       x_sum;
    logic signed [34:0]       y_sum;
    logic signed [WORD_W-1:0] x_next;
    logic signed [WORD_W-1:0] y_next;

    logic                     trig_busy;
    logic signed [WORD_W-1:0] cos_val;
    logic signed [WORD_W-1:0] sin_val;
    logic                     wrap_busy;
    logic signed [HEAD_W-1:0] heading_next;

    ddo_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.load),
        .angle   (heading_reg),
        .busy    (trig_busy),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    ddo_wrap #(
        .FRAC_BITS (FRAC_BITS)
    ) u_wrap (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.wrap_start),
        .heading (heading_reg),
        .ang     (ang_reg),
        .busy    (wrap_busy),
        .result  (heading_next)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_radius_reg <= HALF_RADIUS_RST;
            hrb_reg         <= HALF_RADIUS_OVER_BASIS_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_HALF_RADIUS)
            begin
                half_radius_reg <= cfg_data[HR_W-1:0];
            end
            else if (cfg_index == CFG_HALF_RADIUS_OVER_BASIS)
            begin
                hrb_reg <= cfg_data;
            end
        end
    end

    // exact wheel deltas
    assign dl_next   = 33'(left_angle) - 33'(prev_left_reg);
    assign dr_next   = 33'(right_angle) - 33'(prev_right_reg);
    assign sum_next  = 34'(dl_next) + 34'(dr_next);
    assign diff_next = 34'(dr_next) - 34'(dl_next);

    // shared multiplier operand select
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_LIN:
            begin
                mul_a = sum_reg;
                mul_b = $signed({16'b0, half_radius_reg});
            end
            MUL_ANG:
            begin
                mul_a = diff_reg;
                mul_b = $signed({12'b0, hrb_reg});
            end
            MUL_COS:
            begin
                mul_a = 34'(lin_reg);
                mul_b = cos_val;
            end
            MUL_SIN:
            begin
                mul_a = 34'(lin_reg);
                mul_b = sin_val;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign step_next = sat32((prod_reg + ROUND_F) >>> FRAC_BITS);
    assign trig_wide = (prod_reg + ROUND_TRIG) >>> 30;

    assign x_sum  = 35'(x_reg) + 35'(dx_reg);
    assign y_sum  = 35'(y_reg) + 35'(dy_reg);
    assign x_next = sat32(66'(x_sum));
    assign y_next = sat32(66'(y_sum));

    // state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            have_prev_reg  <= 1'b0;
            x_reg          <= '0;
            y_reg          <= '0;
            heading_reg    <= '0;
            count_reg      <= '0;
            tag_reg        <= MUL_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tag_reg <= cmd.mul_sel;
            if (cmd.prime || cmd.load)
            begin
                prev_left_reg  <= left_angle;
                prev_right_reg <= right_angle;
            end
            if (cmd.prime)
            begin
                have_prev_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                x_reg         <= x_next;
                y_reg         <= y_next;
                heading_reg   <= heading_next;
                count_reg     <= count_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sum_reg  <= sum_next;
            diff_reg <= diff_next;
        end
        prod_reg <= prod_next;
        unique case (tag_reg)
            MUL_LIN: lin_reg <= step_next;
            MUL_ANG: ang_reg <= step_next;
            MUL_COS: dx_reg  <= trig_wide[33:0];
            MUL_SIN: dy_reg  <= trig_wide[33:0];
            default:
            begin
            end
        endcase
        if (cmd.commit)
        begin
            ox_reg      <= x_next;
            oy_reg      <= y_next;
            oh_reg      <= heading_next;
            olin_reg    <= lin_reg;
            oang_reg    <= ang_reg;
            onoturn_reg <= (ang_reg == '0);
            oseq_reg    <= count_reg;
        end
    end

    assign sts.have_prev = have_prev_reg;
    assign sts.trig_busy = trig_busy;
    assign sts.wrap_busy = wrap_busy;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign pos_x        = ox_reg;
    assign pos_y        = oy_reg;
    assign heading      = oh_reg;
    assign linear_step  = olin_reg;
    assign angular_step = oang_reg;
    assign no_turn      = onoturn_reg;
    assign sequence_res = oseq_reg;

    a_commit_after_units: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !trig_busy && !wrap_busy)
        else $error("result committed while trig or wrap unit still running");

    a_commit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before it was taken");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_trig_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !trig_busy)
        else $error("trig unit restarted mid-flight");

    a_heading_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (heading_reg >= -PI_H) && (heading_reg < PI_H))
        else $error("heading state outside [-pi, pi)");

endmodule

[design/ddo_ctrl.sv]
// ddo_ctrl: sequencer for the odometry datapath
// depends on ddo_pkg
module ddo_ctrl
    import ddo_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ddo_sts_t sts,
    output ddo_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd.prime      = 1'b0;
        cmd.load       = 1'b0;
        cmd.mul_sel    = MUL_NONE;
        cmd.wrap_start = 1'b0;
        cmd.commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sts.have_prev)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_MUL_LIN;
                    end
                    else
                    begin
                        cmd.prime = 1'b1;
                    end
                end
            end
            ST_MUL_LIN:
            begin
                cmd.mul_sel = MUL_LIN;
                state_next  = ST_MUL_ANG;
            end
            ST_MUL_ANG:
            begin
                cmd.mul_sel = MUL_ANG;
                state_next  = ST_ANG_TAKE;
            end
            ST_ANG_TAKE:
            begin
                state_next = ST_WRAP_START;
            end
            ST_WRAP_START:
            begin
                cmd.wrap_start = 1'b1;
                state_next     = ST_TRIG_WAIT;
            end
            ST_TRIG_WAIT:
            begin
                if (!sts.trig_busy)
                begin
                    cmd.mul_sel = MUL_COS;
                    state_next  = ST_MUL_SIN;
                end
            end
            ST_MUL_SIN:
            begin
                cmd.mul_sel = MUL_SIN;
                state_next  = ST_SIN_TAKE;
            end
            ST_SIN_TAKE:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!sts.wrap_busy && sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[dv/ddo_pose_checker.sv]
// ddo_pose_checker: watches the wheel-angle, pose-result and register-write channels of
// diff_drive_odometry, predicts every pose result and compares it field by field
// depends on ddo_pkg for widths and register indexes

module ddo_pose_checker
    import ddo_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    localparam int HEAD_W       = FRAC_BITS + 3,
    localparam int OUT_BITS     = 5 * WORD_W + HEAD_W + 1,
    localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [2*ANGLE_W-1:0]   s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_W-1:0]       m_axis_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending,
    output int                     poses_checked
);

    // result field positions, lowest first
    localparam int HEAD_LSB = 2 * WORD_W;
    localparam int LIN_LSB  = HEAD_LSB + HEAD_W;
    localparam int ANG_LSB  = LIN_LSB + WORD_W;
    localparam int TURN_BIT = ANG_LSB + WORD_W;
    localparam int SEQ_LSB  = TURN_BIT + 1;

    localparam logic [HR_W-1:0]  RADIUS_HALF_INIT = 16'd918;
    localparam logic [HRB_W-1:0] TURN_GAIN_INIT   = 20'd14680;

    localparam longint PI_Q32_REF   = 64'sd13493037705;
    localparam longint PI_Q30_REF   = 64'sd3373259426;
    localparam longint HALF_PI_Q30  = 64'sd1686629713;
    localparam longint CORDIC_SCALE = 64'sd652032874;
    localparam longint PI_FRAC      = ((PI_Q32_REF - 64'sd1) >>> (32 - FRAC_BITS)) + 64'sd1;
    localparam longint TURN_PERIOD  = 2 * PI_FRAC;

    typedef struct {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [HEAD_W-1:0] heading;
        logic signed [WORD_W-1:0] linear_step;
        logic signed [WORD_W-1:0] angular_step;
        logic                     no_turn;
        logic [WORD_W-1:0]        sequence_res;
    } pose_result_t;

    pose_result_t expected_poses[$];

    logic [HR_W-1:0]  half_radius;
    logic [HRB_W-1:0] turn_gain;
    longint           last_left;
    longint           last_right;
    longint           x_pos;
    longint           y_pos;
    longint           heading_q;
    logic             primed;
    logic [WORD_W-1:0] pose_seq;
    int               mismatches = 0;
    int               checked = 0;

    initial
    begin
        fail_count    = 0;
        pending       = 0;
        poses_checked = 0;
    end

    function automatic longint clamp32(input longint v);
        longint res;
        if (v > 64'sd2147483647)
        begin
            res = 64'sd2147483647;
        end
        else if (v < -64'sd2147483648)
        begin
            res = -64'sd2147483648;
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic longint round_frac(input longint v);
        return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    // arctangent of 2^-i in Q2.30
    function automatic longint cordic_angle(input int i);
        longint res;
        case (i)
            0:       res = 64'h3243F6A8;
            1:       res = 64'h1DAC6705;
            2:       res = 64'h0FADBAFC;
            3:       res = 64'h07F56EA6;
            4:       res = 64'h03FEAB76;
            5:       res = 64'h01FFD55B;
            6:       res = 64'h00FFFAAA;
            7:       res = 64'h007FFF55;
            8:       res = 64'h003FFFEA;
            9:       res = 64'h001FFFFD;
            10:      res = 64'h000FFFFF;
            11:      res = 64'h0007FFFF;
            12:      res = 64'h0003FFFF;
            13:      res = 64'h0001FFFF;
            14:      res = 64'h0000FFFF;
            15:      res = 64'h00007FFF;
            16:      res = 64'h00003FFF;
            17:      res = 64'h00001FFF;
            18:      res = 64'h00000FFF;
            19:      res = 64'h000007FF;
            20:      res = 64'h000003FF;
            21:      res = 64'h000001FF;
            22:      res = 64'h000000FF;
            23:      res = 64'h0000007F;
            default: res = 64'h0;
        endcase
        return res;
    endfunction

    // cos and sin of a heading, Q2.30
    task automatic heading_trig(input longint head, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        logic   folded;
        int     i;
        z = head * (64'sd1 <<< (30 - FRAC_BITS));
        x = CORDIC_SCALE;
        y = 0;
        folded = 1'b0;
        // fold the outer half-circle onto the inner one
        if (z > HALF_PI_Q30)
        begin
            z = z - PI_Q30_REF;
            folded = 1'b1;
        end
        else if (z < -HALF_PI_Q30)
        begin
            z = z + PI_Q30_REF;
            folded = 1'b1;
        end
        for (i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - cordic_angle(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + cordic_angle(i);
            end
        end
        c = folded ? -x : x;
        s = folded ? -y : y;
    endtask

    // one wheel sample: prime the stored angles or advance the pose
    task automatic advance_pose(input logic signed [ANGLE_W-1:0] left,
                                input logic signed [ANGLE_W-1:0] right);
        longint       dl;
        longint       dr;
        longint       lin;
        longint       ang;
        longint       c;
        longint       s;
        longint       wrapped;
        pose_result_t pose;
        if (!primed)
        begin
            last_left  = left;
            last_right = right;
            primed     = 1'b1;
        end
        else
        begin
            dl = longint'(left) - last_left;
            dr = longint'(right) - last_right;
            last_left  = left;
            last_right = right;
            lin = clamp32(round_frac((dl + dr) * longint'(half_radius)));
            ang = clamp32(round_frac((dr - dl) * longint'(turn_gain)));
            // position moves along the heading from before this sample
            heading_trig(heading_q, c, s);
            x_pos = clamp32(x_pos + ((lin * c + (64'sd1 <<< 29)) >>> 30));
            y_pos = clamp32(y_pos + ((lin * s + (64'sd1 <<< 29)) >>> 30));
            wrapped = (heading_q + ang + PI_FRAC) % TURN_PERIOD;
            if (wrapped < 0)
            begin
                wrapped = wrapped + TURN_PERIOD;
            end
            heading_q = wrapped - PI_FRAC;
            pose.pos_x        = x_pos[WORD_W-1:0];
            pose.pos_y        = y_pos[WORD_W-1:0];
            pose.heading      = heading_q[HEAD_W-1:0];
            pose.linear_step  = lin[WORD_W-1:0];
            pose.angular_step = ang[WORD_W-1:0];
            pose.no_turn      = (ang == 0);
            pose.sequence_res = pose_seq;
            pose_seq = pose_seq + 1'b1;
            expected_poses.push_back(pose);
        end
    endtask

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_pose(input logic [OUT_W-1:0] word);
        pose_result_t want;
        pose_result_t got;
        got.pos_x        = word[0 +: WORD_W];
        got.pos_y        = word[WORD_W +: WORD_W];
        got.heading      = word[HEAD_LSB +: HEAD_W];
        got.linear_step  = word[LIN_LSB +: WORD_W];
        got.angular_step = word[ANG_LSB +: WORD_W];
        got.no_turn      = word[TURN_BIT];
        got.sequence_res = word[SEQ_LSB +: WORD_W];
        if (expected_poses.size() == 0)
        begin
            $error("pose result with no wheel sample waiting for it");
            mismatches++;
        end
        else
        begin
            want = expected_poses.pop_front();
            checked++;
            compare_field("pos_x", longint'(want.pos_x), longint'(got.pos_x));
            compare_field("pos_y", longint'(want.pos_y), longint'(got.pos_y));
            compare_field("heading", longint'(want.heading), longint'(got.heading));
            compare_field("linear_step", longint'(want.linear_step),
                          longint'(got.linear_step));
            compare_field("angular_step", longint'(want.angular_step),
                          longint'(got.angular_step));
            compare_field("no_turn", longint'(want.no_turn), longint'(got.no_turn));
            compare_field("sequence_res", longint'(want.sequence_res),
                          longint'(got.sequence_res));
            compare_field("pad", 0, longint'(word >> OUT_BITS));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_radius = RADIUS_HALF_INIT;
            turn_gain   = TURN_GAIN_INIT;
            last_left   = 0;
            last_right  = 0;
            x_pos       = 0;
            y_pos       = 0;
            heading_q   = 0;
            primed      = 1'b0;
            pose_seq    = '0;
            expected_poses.delete();
            pending    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_pose(m_axis_tdata);
            end
            // other indexes and bits above a register's width are dropped
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_HALF_RADIUS)
                begin
                    half_radius = cfg_data[HR_W-1:0];
                end
                else if (cfg_index == CFG_HALF_RADIUS_OVER_BASIS)
                begin
                    turn_gain = cfg_data[HRB_W-1:0];
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_pose(s_axis_tdata[0 +: ANGLE_W], s_axis_tdata[ANGLE_W +: ANGLE_W]);
            end
            pending       <= expected_poses.size();
            fail_count    <= mismatches;
            poses_checked <= checked;
        end
    end

endmodule

[dv/testbench.sv]
// testbench: drives wheel-angle items and register writes into diff_drive_odometry and
// gives the verdict; prediction and comparison live in ddo_pose_checker
// depends on ddo_pkg, ddo_pose_checker and the design under design/

module testbench;
    import ddo_pkg::*;

    localparam int HEAD_W   = FRAC_BITS_DEF + 3;
    localparam int OUT_BITS = 5 * WORD_W + HEAD_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // cycles the block may still work on an item that gives no result
    localparam int SETTLE_CYCLES = CORDIC_STAGES_DEF + 8;
    // receiver hold-off, long enough for the block to fill and stall its input
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 75;
    localparam int IDLE_PERCENT  = 29;

    // register indexes the block does not have
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LOW  = CFG_HALF_RADIUS_OVER_BASIS + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HIGH = '1;

    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN    = 32'sh8000_0000;
    localparam logic signed [ANGLE_W-1:0] QUARTER_SPAN = 32'sh4000_0000;
    localparam logic signed [ANGLE_W-1:0] SPIN_STEP    = 32'sh0004_0000;

    typedef enum logic {
        PACE_RANDOM,
        PACE_STEADY
    } pace_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [2*ANGLE_W-1:0]   s_axis_tdata = '0;   // left_angle, right_angle
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_W-1:0]       m_axis_tdata;        // pos_x, pos_y, heading, linear_step,
                                                 // angular_step, no_turn, sequence_res, pad
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int poses_checked;

    // both sides read the pace; the receiver alone counts out its hold-off
    pace_t       pace = PACE_RANDOM;
    int unsigned hold_kick = 0;
    int unsigned kick_seen = 0;
    int          hold_left = 0;

    // current absolute wheel angles, random motion continues from here
    logic signed [ANGLE_W-1:0] cur_left = '0;
    logic signed [ANGLE_W-1:0] cur_right = '0;
    int items_sent = 0;
    int reg_writes = 0;
    int settings_used = 1;

    always
    begin
        #4 clk = ~clk;
    end

    diff_drive_odometry u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    ddo_pose_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .poses_checked (poses_checked)
    );

    // result side: random stalls, steady stretches, and one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_kick != kick_seen)
        begin
            kick_seen = hold_kick;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (pace == PACE_STEADY)
        begin
            m_axis_tready <= 1'b1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // offer one wheel-angle item, maybe after a gap, and wait until it is taken
    task automatic send_angles(input logic signed [ANGLE_W-1:0] left,
                               input logic signed [ANGLE_W-1:0] right);
        if (pace == PACE_RANDOM && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 56)) @(posedge clk);
        end
        cur_left  = left;
        cur_right = right;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        items_sent++;
    endtask

    // mostly smooth wheel motion with random content, some jumps and pure noise
    task automatic send_random_motion();
        int unsigned pick;
        logic signed [ANGLE_W-1:0] dl;
        logic signed [ANGLE_W-1:0] dr;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            send_angles($urandom, $urandom);
        end
        else
        begin
            if (pick < 20)
            begin
                dl = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
            end
            else
            begin
                dl = $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
            end
            // straight runs give no turn, spins give no travel
            if (pick < 40)
            begin
                dr = dl;
            end
            else if (pick < 52)
            begin
                dr = -dl;
            end
            else
            begin
                dr = $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
            end
            send_angles(cur_left + dl, cur_right + dr);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // stop offering, wait for every expected pose, then let the sequencer go idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: priming sample, no motion, full-scale jumps, spin through +-pi
        send_angles('0, '0);
        send_angles('0, '0);
        send_angles(ANGLE_MAX, ANGLE_MAX);
        send_angles(ANGLE_MIN, ANGLE_MIN);
        send_angles(ANGLE_MAX, ANGLE_MIN);
        send_angles(ANGLE_MIN, ANGLE_MAX);
        repeat (5) send_angles(cur_left - SPIN_STEP, cur_right + SPIN_STEP);
        settle();

        // largest registers: both steps saturate, then drive x and y into their limits
        write_reg(CFG_HALF_RADIUS, 20'h0_FFFF);
        write_reg(CFG_HALF_RADIUS_OVER_BASIS, 20'hF_FFFF);
        settings_used++;
        send_angles(ANGLE_MAX, ANGLE_MAX);
        send_angles(ANGLE_MIN, ANGLE_MIN);
        send_angles(ANGLE_MAX, ANGLE_MIN);
        send_angles(ANGLE_MIN, ANGLE_MAX);
        send_angles(ANGLE_MIN, ANGLE_MIN);
        send_angles(-QUARTER_SPAN, -QUARTER_SPAN);
        send_angles('0, '0);
        send_angles(QUARTER_SPAN, QUARTER_SPAN);
        send_angles('0, '0);
        send_angles(-QUARTER_SPAN, -QUARTER_SPAN);
        send_angles(ANGLE_MIN, ANGLE_MIN);
        settle();

        // zero registers; the half_radius write only sets bits above its width
        write_reg(CFG_HALF_RADIUS, 20'hF_0000);
        write_reg(CFG_HALF_RADIUS_OVER_BASIS, '0);
        settings_used++;
        send_angles(ANGLE_MAX, ANGLE_MIN);
        send_angles(ANGLE_MIN, ANGLE_MAX);
        send_angles('0, '0);
        settle();

        // realistic registers; receiver holds off so the block backs up
        write_reg(CFG_HALF_RADIUS, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_HALF_RADIUS_OVER_BASIS, CFG_DATA_W'($urandom_range(0, 20'h3_FFFF)));
        settings_used++;
        hold_kick <= hold_kick + 1;
        repeat (RANDOM_ITEMS) send_random_motion();
        settle();

        // writes to missing indexes must leave the registers alone; no idling at all here
        write_reg(CFG_UNUSED_LOW, CFG_DATA_W'($urandom));
        write_reg(CFG_UNUSED_HIGH, CFG_DATA_W'($urandom));
        pace <= PACE_STEADY;
        repeat (RANDOM_ITEMS) send_random_motion();
        pace <= PACE_RANDOM;
        settle();

        // registers anywhere in their range
        write_reg(CFG_HALF_RADIUS, CFG_DATA_W'($urandom));
        write_reg(CFG_HALF_RADIUS_OVER_BASIS, CFG_DATA_W'($urandom));
        settings_used++;
        repeat (RANDOM_ITEMS) send_random_motion();
        settle();

        // back to the power-on values
        write_reg(CFG_HALF_RADIUS, 20'd918);
        write_reg(CFG_HALF_RADIUS_OVER_BASIS, 20'd14680);
        settings_used++;
        repeat (RANDOM_ITEMS) send_random_motion();
        settle();

        $display("covered %0d wheel samples (one priming) and %0d pose results",
                 items_sent, poses_checked);
        $display("over %0d register settings made by %0d writes", settings_used, reg_writes);
        if (fail_count == 0 && pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, many times the slowest expected run
    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
design/ddo_pkg.sv
design/ddo_cordic.sv
design/ddo_wrap.sv
design/ddo_datapath.sv
design/ddo_ctrl.sv
design/diff_drive_odometry.sv
dv/ddo_pose_checker.sv
dv/testbench.sv
